// ===== hw/rtl/date_day_difference_assert.svh =====
// Assertion macros for the date day difference block.
// No dependencies; included by the top level only.
`ifndef DATE_DAY_DIFFERENCE_ASSERT_SVH
`define DATE_DAY_DIFFERENCE_ASSERT_SVH

`ifndef SYNTHESIS
`define DDD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ddd assertion failed");
`define DDD_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ddd reset assertion failed");
`else
`define DDD_ASSERT(label, clk, rstn, prop)
`define DDD_ASSERT_RST(label, clk, prop)
`endif

`endif

// ===== hw/rtl/ddd_pkg.sv =====
// Shared widths, calendar tables and pipeline control type for the date day difference block.
// No dependencies.
package ddd_pkg;

    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_W     = 14;
    localparam int DOY_W      = 9;
    localparam int NUM_W      = 22;
    localparam int DIFF_W     = 23;
    localparam int Q_W        = 8;
    localparam int RECIP_W    = 13;
    localparam int RECIP_100  = 5243;
    localparam int RECIP_SH   = 19;
    localparam int CENTURY    = 100;
    localparam int DAYS_YEAR  = 365;
    localparam int YEAR_MIN   = 1;
    localparam int YEAR_MAX   = 9999;
    localparam int MON_MAX    = 12;
    localparam int MON_FEB    = 2;
    localparam int FEB_LEAP   = 29;
    localparam int MAX_DIFF   = 3652058;

    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 24;

    typedef struct packed {
        logic ld1;
        logic ld2;
    } ddd_ctrl_t;

    // Month length in a common year; zero for codes that are not months.
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                     len = DAY_W'(30);
            4'd2:                                        len = DAY_W'(28);
            default:                                     len = '0;
        endcase
        return len;
    endfunction

    // Days from 1 March to the first of month m, year taken to start in March.
    function automatic logic [DOY_W-1:0] march_offset(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] off;
        unique case (m)
            4'd3:    off = DOY_W'(0);
            4'd4:    off = DOY_W'(31);
            4'd5:    off = DOY_W'(61);
            4'd6:    off = DOY_W'(92);
            4'd7:    off = DOY_W'(122);
            4'd8:    off = DOY_W'(153);
            4'd9:    off = DOY_W'(184);
            4'd10:   off = DOY_W'(214);
            4'd11:   off = DOY_W'(245);
            4'd12:   off = DOY_W'(275);
            4'd1:    off = DOY_W'(306);
            4'd2:    off = DOY_W'(337);
            default: off = '0;
        endcase
        return off;
    endfunction

endpackage

// ===== hw/rtl/ddd_day_number.sv =====
// Two-stage day number unit: one Gregorian date to a March-based day count plus validity.
// Depends on ddd_pkg.
module ddd_day_number (
    input  logic                       aclk,
    input  ddd_pkg::ddd_ctrl_t         ctrl,
    input  logic [ddd_pkg::DAY_W-1:0]  day,
    input  logic [ddd_pkg::MON_W-1:0]  month,
    input  logic [ddd_pkg::YEAR_W-1:0] year,
    output logic [ddd_pkg::NUM_W-1:0]  num,
    output logic                       ok
);
    import ddd_pkg::*;

    localparam int PROD_W = YEAR_W + RECIP_W;
    localparam int SUM_W  = NUM_W + 2;

    // stage 1
    logic [YEAR_W-1:0] ya_next, ya_reg;
    logic [YEAR_W-1:0] y_reg;
    logic [Q_W-1:0]    qa_next, qa_reg;
    logic [Q_W-1:0]    qy_next, qy_reg;
    logic [DOY_W-1:0]  doy_next, doy_reg;
    logic              base_ok_next, base_ok_reg;
    logic              need_leap_next, need_leap_reg;
    logic [PROD_W-1:0] prod_a, prod_y;
    logic [DAY_W-1:0]  len;
    logic              is_feb;

    // stage 2
    logic [YEAR_W-1:0] hund;
    logic              div100, leap;
    logic [SUM_W-1:0]  sum;
    logic [NUM_W-1:0]  num_next, num_reg;
    logic              ok_next, ok_reg;

    always_comb begin
        is_feb         = (month == MON_W'(MON_FEB));
        ya_next        = (month <= MON_W'(MON_FEB)) ? year - YEAR_W'(1) : year;
        prod_a         = PROD_W'(ya_next) * PROD_W'(RECIP_100);
        prod_y         = PROD_W'(year) * PROD_W'(RECIP_100);
        qa_next        = prod_a[RECIP_SH +: Q_W];
        qy_next        = prod_y[RECIP_SH +: Q_W];
        doy_next       = march_offset(month) + DOY_W'(day) - DOY_W'(1);
        len            = month_len(month);
        need_leap_next = is_feb && (day == DAY_W'(FEB_LEAP));
        base_ok_next   = (month >= MON_W'(1)) && (month <= MON_W'(MON_MAX))
                      && (year >= YEAR_W'(YEAR_MIN)) && (year <= YEAR_W'(YEAR_MAX))
                      && (day != '0) && ((day <= len) || need_leap_next);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld1) begin
            ya_reg        <= ya_next;
            y_reg         <= year;
            qa_reg        <= qa_next;
            qy_reg        <= qy_next;
            doy_reg       <= doy_next;
            base_ok_reg   <= base_ok_next;
            need_leap_reg <= need_leap_next;
        end
    end

    always_comb begin
        hund     = YEAR_W'(qy_reg) * YEAR_W'(CENTURY);
        div100   = (y_reg == hund);
        leap     = ((y_reg[1:0] == 2'b00) && !div100) || (div100 && (qy_reg[1:0] == 2'b00));
        ok_next  = base_ok_reg && (!need_leap_reg || leap);
        sum      = SUM_W'(ya_reg) * SUM_W'(DAYS_YEAR) + SUM_W'(ya_reg >> 2)
                 + SUM_W'(qa_reg >> 2) + SUM_W'(doy_reg) - SUM_W'(qa_reg);
        num_next = sum[NUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld2) begin
            num_reg <= num_next;
            ok_reg  <= ok_next;
        end
    end

    assign num = num_reg;
    assign ok  = ok_reg;

endmodule

// ===== hw/rtl/date_day_difference.sv =====
// Date day difference: signed days between two Gregorian dates. Uses ddd_pkg, ddd_day_number.
// Each accepted transaction passes the split, day number and difference registers to m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls; three register stages, each with
// its own valid bit, hold the constant-multiply century split, day number sum and difference.
// Reset: synchronous active-low aresetn clears all stage valid bits; data registers keep contents.
module date_day_difference (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // start_day, start_month, start_year, end_day, end_month, end_year, zero pad
    input  logic [ddd_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // day_difference, zero pad
    output logic [ddd_pkg::M_DATA_W-1:0] m_tdata,
    // invalid_date
    output logic                         m_tuser
);
    import ddd_pkg::*;

    logic              v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic              adv1, adv2, adv3;
    ddd_ctrl_t         ctrl;
    logic [NUM_W-1:0]  ns, ne;
    logic              oks, oke;
    logic [DIFF_W-1:0] diff_next, diff_reg;
    logic              inv_next, inv_reg;

    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;
    assign ctrl     = '{ld1: adv1, ld2: adv2};

    ddd_day_number u_start (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .day   (s_tdata[4:0]),
        .month (s_tdata[8:5]),
        .year  (s_tdata[22:9]),
        .num   (ns),
        .ok    (oks)
    );

    ddd_day_number u_end (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .day   (s_tdata[27:23]),
        .month (s_tdata[31:28]),
        .year  (s_tdata[45:32]),
        .num   (ne),
        .ok    (oke)
    );

    always_comb begin
        v1_next   = adv1 ? s_tvalid : v1_reg;
        v2_next   = adv2 ? v1_reg : v2_reg;
        v3_next   = adv3 ? v2_reg : v3_reg;
        inv_next  = !(oks && oke);
        diff_next = inv_next ? '0 : DIFF_W'({1'b0, ne}) - DIFF_W'({1'b0, ns});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            diff_reg <= diff_next;
            inv_reg  <= inv_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(M_DATA_W-DIFF_W){1'b0}}, diff_reg};
    assign m_tuser  = inv_reg;

`include "date_day_difference_assert.svh"

    `DDD_ASSERT(a_invalid_zero, aclk, aresetn, m_tvalid && m_tuser |-> diff_reg == '0)
    `DDD_ASSERT(a_stall_full, aclk, aresetn, !s_tready |-> v1_reg && v2_reg && v3_reg)
    `DDD_ASSERT(a_no_invent, aclk, aresetn, m_tvalid && m_tready && !v2_reg |=> !m_tvalid)
    `DDD_ASSERT(a_diff_range, aclk, aresetn,
        m_tvalid |-> ($signed(diff_reg) <= MAX_DIFF) && ($signed(diff_reg) >= -MAX_DIFF))
    `DDD_ASSERT_RST(a_reset_clear, aclk, !aresetn |=> !v1_reg && !v2_reg && !v3_reg)

endmodule
